// File: rtl/ilra_pkg.sv
// shared types and constants for the indexed list remove and advance block
package ilra_pkg;

  // list geometry
  localparam int MAX_ENTRIES = 1024;
  localparam int ID_W        = 11;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int NXT_W       = ID_W + 1;   // member mark over successor link
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam logic [ID_W-1:0] COUNT_RESET = ID_W'(1024);

  // command codes
  typedef enum logic [1:0] {
    CMD_INIT    = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_SAME = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // request payload
  typedef struct packed {
    cmd_t            cmd;
    logic [ID_W-1:0] entry;
  } req_t;

  // response payload
  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] next_id;
    logic [ID_W-1:0] prev_id;
    logic [ID_W-1:0] head_id;
    logic [ID_W-1:0] tail_id;
  } rsp_t;

endpackage

// File: rtl/indexed_list_remove_and_advance.sv
// indexed doubly linked list with init, remove, advance and query commands
//
//   channel   direction  transfer when            payload
//   req       in         req_valid & req_ready    ilra_pkg::req_t (cmd, entry)
//   rsp       out        rsp_valid & rsp_ready    ilra_pkg::rsp_t (status, links, head, tail)
//   apb       in/out     psel & penable & pwrite  entry_count at byte address 0
//
// steps, each ending in result: query or rejected look; remove look, link1, link2; advance
// look, pred, link1, link2, link3 (of head look); init a sweep of all entries. every step is
// one access to the successor and predecessor rams. after rst a clearing sweep drops all
// member marks; req_ready stays low meanwhile. one command is in flight at a time; a finished
// response waits in the rsp register, and a stalled rsp holds the sequencer in its result step.
module indexed_list_remove_and_advance (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  ilra_pkg::req_t                     req,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output ilra_pkg::rsp_t                     rsp,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ilra_pkg::PADDR_W-1:0]       paddr,
  input  logic [ilra_pkg::PDATA_W-1:0]       pwdata,
  output logic [ilra_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  localparam int ID_W   = ilra_pkg::ID_W;
  localparam int ADDR_W = ilra_pkg::ADDR_W;
  localparam int NXT_W  = ilra_pkg::NXT_W;
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(ilra_pkg::MAX_ENTRIES - 1);
  localparam logic [ID_W-1:0]   MAX_ID   = ID_W'(ilra_pkg::MAX_ENTRIES);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SWEEP  = 8'b0000_0010,
    S_LOOK   = 8'b0000_0100,
    S_PRED   = 8'b0000_1000,
    S_LINK1  = 8'b0001_0000,
    S_LINK2  = 8'b0010_0000,
    S_LINK3  = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

  // id to ram address (ids start at one)
  function automatic logic [ADDR_W-1:0] addr_of(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] t;
    t = id - ID_W'(1);
    return t[ADDR_W-1:0];
  endfunction

  state_t            state;
  logic              boot;
  ilra_pkg::cmd_t    cmd;
  logic [ID_W-1:0]   x;
  logic              x_ok;
  logic [ID_W-1:0]   p;
  logic [ID_W-1:0]   nx;
  logic [ID_W-1:0]   pp;
  logic [ID_W-1:0]   n;
  logic [ID_W-1:0]   head;
  logic [ID_W-1:0]   tail;
  logic [ADDR_W-1:0] idx;
  logic [ID_W-1:0]   entry_count;
  ilra_pkg::status_t res_status;
  logic [ID_W-1:0]   res_next;
  logic [ID_W-1:0]   res_prev;

  logic              nxt_we;
  logic [ADDR_W-1:0] nxt_waddr;
  logic [NXT_W-1:0]  nxt_wdata;
  logic [ADDR_W-1:0] nxt_raddr;
  logic [NXT_W-1:0]  nxt_rdata;
  logic              prv_we;
  logic [ADDR_W-1:0] prv_waddr;
  logic [ID_W-1:0]   prv_wdata;
  logic [ADDR_W-1:0] prv_raddr;
  logic [ID_W-1:0]   prv_rdata;

  logic              rd_mark;
  logic [ID_W-1:0]   rd_next;
  logic [ID_W-1:0]   sweep_id;
  logic [ID_W-1:0]   cnt_sat;
  logic              cfg_wr;
  logic              slot_free;

  assign rd_mark   = nxt_rdata[NXT_W-1];
  assign rd_next   = nxt_rdata[ID_W-1:0];
  assign sweep_id  = ID_W'(idx) + ID_W'(1);
  assign cnt_sat   = (entry_count > MAX_ID) ? MAX_ID : entry_count;
  assign req_ready = (state == S_IDLE);
  assign slot_free = !rsp_valid || rsp_ready;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == 1'b0) ? ilra_pkg::PDATA_W'(entry_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= ilra_pkg::COUNT_RESET;
    end else if (cfg_wr && paddr[2] == 1'b0) begin
      entry_count <= pwdata[ID_W-1:0];
    end
  end

  // link tables
  ilra_ram #(.WIDTH(NXT_W), .DEPTH(ilra_pkg::MAX_ENTRIES)) u_nxt_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (nxt_raddr),
    .rdata (nxt_rdata)
  );

  ilra_ram #(.WIDTH(ID_W), .DEPTH(ilra_pkg::MAX_ENTRIES)) u_prv_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .raddr (prv_raddr),
    .rdata (prv_rdata)
  );

  // read addresses: entry on accept, predecessor's predecessor during lookup
  always_comb begin
    nxt_raddr = addr_of(x);
    prv_raddr = addr_of(x);
    if (state == S_IDLE) begin
      nxt_raddr = addr_of(req.entry);
      prv_raddr = addr_of(req.entry);
    end else if (state == S_LOOK) begin
      prv_raddr = addr_of(prv_rdata);
    end
  end

  // write ports per sequencer step
  always_comb begin
    nxt_we    = 1'b0;
    nxt_waddr = addr_of(x);
    nxt_wdata = '0;
    prv_we    = 1'b0;
    prv_waddr = addr_of(x);
    prv_wdata = '0;
    unique case (state)
      S_SWEEP: begin
        nxt_we    = 1'b1;
        nxt_waddr = idx;
        nxt_wdata = {(sweep_id <= n), (sweep_id < n) ? sweep_id + ID_W'(1) : ID_W'(0)};
        prv_we    = 1'b1;
        prv_waddr = idx;
        prv_wdata = ID_W'(idx);
      end
      S_LINK1: begin
        if (cmd == ilra_pkg::CMD_REMOVE) begin
          nxt_we    = (p != '0);
          nxt_waddr = addr_of(p);
          nxt_wdata = {1'b1, nx};
        end else begin
          nxt_we    = (pp != '0);
          nxt_waddr = addr_of(pp);
          nxt_wdata = {1'b1, x};
        end
        prv_we    = (nx != '0);
        prv_waddr = addr_of(nx);
        prv_wdata = p;
      end
      S_LINK2: begin
        nxt_we    = 1'b1;
        nxt_waddr = addr_of(x);
        if (cmd == ilra_pkg::CMD_REMOVE) begin
          nxt_wdata = {1'b0, nx};
        end else begin
          nxt_wdata = {1'b1, p};
          prv_we    = 1'b1;
          prv_waddr = addr_of(x);
          prv_wdata = pp;
        end
      end
      S_LINK3: begin
        nxt_we    = 1'b1;
        nxt_waddr = addr_of(p);
        nxt_wdata = {1'b1, nx};
        prv_we    = 1'b1;
        prv_waddr = addr_of(p);
        prv_wdata = x;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      boot      <= 1'b1;
      idx       <= '0;
      n         <= '0;
      head      <= '0;
      tail      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // the result step sets rsp_valid itself
      if (rsp_valid && rsp_ready && state != S_RESULT) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd  <= req.cmd;
            x    <= req.entry;
            x_ok <= (req.entry != '0) && (req.entry <= MAX_ID);
            if (req.cmd == ilra_pkg::CMD_INIT) begin
              n     <= cnt_sat;
              idx   <= '0;
              head  <= (cnt_sat != '0) ? ID_W'(1) : ID_W'(0);
              tail  <= cnt_sat;
              state <= S_SWEEP;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_SWEEP: begin
          idx <= idx + ADDR_W'(1);
          if (idx == LAST_IDX) begin
            boot       <= 1'b0;
            res_status <= ilra_pkg::ST_DONE;
            if (x_ok && x <= n) begin
              res_next <= (x < n) ? x + ID_W'(1) : ID_W'(0);
              res_prev <= x - ID_W'(1);
            end else begin
              res_next <= '0;
              res_prev <= '0;
            end
            state <= boot ? S_IDLE : S_RESULT;
          end
        end
        S_LOOK: begin
          p  <= prv_rdata;
          nx <= rd_next;
          priority if (cmd == ilra_pkg::CMD_QUERY && x == '0) begin
            res_status <= ilra_pkg::ST_DONE;
            res_next   <= head;
            res_prev   <= '0;
            state      <= S_RESULT;
          end else if (!x_ok || !rd_mark) begin
            res_status <= ilra_pkg::ST_BAD;
            res_next   <= '0;
            res_prev   <= '0;
            state      <= S_RESULT;
          end else if (cmd == ilra_pkg::CMD_QUERY) begin
            res_status <= ilra_pkg::ST_DONE;
            res_next   <= rd_next;
            res_prev   <= prv_rdata;
            state      <= S_RESULT;
          end else if (cmd == ilra_pkg::CMD_REMOVE) begin
            state <= S_LINK1;
          end else if (prv_rdata == '0) begin
            res_status <= ilra_pkg::ST_SAME;
            res_next   <= rd_next;
            res_prev   <= '0;
            state      <= S_RESULT;
          end else begin
            state <= S_PRED;
          end
        end
        S_PRED: begin
          pp    <= prv_rdata;
          state <= S_LINK1;
        end
        S_LINK1: begin
          if (cmd == ilra_pkg::CMD_REMOVE) begin
            if (p == '0) begin
              head <= nx;
            end
          end else if (pp == '0) begin
            head <= x;
          end
          if (nx == '0) begin
            tail <= p;
          end
          state <= S_LINK2;
        end
        S_LINK2: begin
          if (cmd == ilra_pkg::CMD_REMOVE) begin
            res_status <= ilra_pkg::ST_DONE;
            res_next   <= '0;
            res_prev   <= '0;
            state      <= S_RESULT;
          end else begin
            state <= S_LINK3;
          end
        end
        S_LINK3: begin
          res_status <= ilra_pkg::ST_DONE;
          res_next   <= p;
          res_prev   <= pp;
          state      <= S_RESULT;
        end
        S_RESULT: begin
          if (slot_free) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (state == S_RESULT && slot_free) begin
      rsp.status  <= res_status;
      rsp.next_id <= res_next;
      rsp.prev_id <= res_prev;
      rsp.head_id <= head;
      rsp.tail_id <= tail;
    end
  end

endmodule

// File: rtl/ilra_ram.sv
// generic single write port ram with registered read
module ilra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: tb/sv/indexed_list_remove_and_advance_test.sv
// self-checking testbench for the indexed list remove and advance block
module indexed_list_remove_and_advance_test;

  localparam int ID_W        = ilra_pkg::ID_W;
  localparam int MAX_ENTRIES = ilra_pkg::MAX_ENTRIES;
  localparam int PADDR_W     = ilra_pkg::PADDR_W;
  localparam int PDATA_W     = ilra_pkg::PDATA_W;
  localparam int IDLE_LIMIT = 20000;   // cycles with no transfer before giving up
  localparam int END_WAIT   = 40;
  localparam int ID_TOP     = (1 << ID_W) - 1;
  localparam logic [PADDR_W-1:0] ADDR_ENTRY_COUNT = PADDR_W'(0);
  localparam logic [PADDR_W-1:0] ADDR_UNUSED      = PADDR_W'(4);

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  ilra_pkg::req_t     req       = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  ilra_pkg::rsp_t     rsp;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // shadow copy of the list kept by the predictor
  logic [ID_W-1:0] succ_link [0:MAX_ENTRIES];
  logic [ID_W-1:0] pred_link [0:MAX_ENTRIES];
  bit              on_list   [0:MAX_ENTRIES];
  logic [ID_W-1:0] list_head = '0;
  logic [ID_W-1:0] list_tail = '0;
  logic [ID_W-1:0] count_reg = ilra_pkg::COUNT_RESET;
  int              list_span = 0;

  ilra_pkg::rsp_t result_q [$];
  ilra_pkg::rsp_t want_rsp;

  int errors        = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles  = 0;
  int reg_writes    = 0;
  int cmd_seen    [4];
  int status_seen [4];

  indexed_list_remove_and_advance u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit listed(logic [ID_W-1:0] x);
    return (x != 0) && (x <= MAX_ENTRIES) && on_list[x];
  endfunction

  // apply one command to the shadow list and return the response it should give
  function automatic ilra_pkg::rsp_t list_apply(ilra_pkg::req_t r);
    ilra_pkg::rsp_t  o;
    logic [ID_W-1:0] x;
    logic [ID_W-1:0] p;
    logic [ID_W-1:0] pp;
    logic [ID_W-1:0] nx;
    int              i;
    o        = '0;
    o.status = ilra_pkg::ST_DONE;
    x        = r.entry;
    if (r.cmd == ilra_pkg::CMD_INIT) begin
      list_span = (count_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(count_reg);
      for (i = 1; i <= MAX_ENTRIES; i++) on_list[i] = 1'b0;
      for (i = 1; i <= list_span; i++) begin
        on_list[i]   = 1'b1;
        pred_link[i] = ID_W'(i - 1);
        succ_link[i] = (i < list_span) ? ID_W'(i + 1) : ID_W'(0);
      end
      list_head = (list_span > 0) ? ID_W'(1) : ID_W'(0);
      list_tail = ID_W'(list_span);
    end else if (r.cmd == ilra_pkg::CMD_QUERY && x == 0) begin
      o.next_id = list_head;
    end else if (!listed(x)) begin
      o.status = ilra_pkg::ST_BAD;
    end else if (r.cmd == ilra_pkg::CMD_REMOVE) begin
      p  = pred_link[x];
      nx = succ_link[x];
      if (p != 0) begin
        succ_link[p] = nx;
      end else begin
        list_head = nx;
      end
      if (nx != 0) begin
        pred_link[nx] = p;
      end else begin
        list_tail = p;
      end
      on_list[x] = 1'b0;
    end else if (r.cmd == ilra_pkg::CMD_ADVANCE) begin
      p = pred_link[x];
      if (p == 0) begin
        o.status = ilra_pkg::ST_SAME;
      end else begin
        pp = pred_link[p];
        nx = succ_link[x];
        if (pp != 0) begin
          succ_link[pp] = x;
        end else begin
          list_head = x;
        end
        if (nx != 0) begin
          pred_link[nx] = p;
        end else begin
          list_tail = p;
        end
        pred_link[x] = pp;
        succ_link[x] = p;
        pred_link[p] = x;
        succ_link[p] = nx;
      end
    end
    // neighbours are reported for any entry that is a member afterwards
    if (listed(x)) begin
      o.next_id = succ_link[x];
      o.prev_id = pred_link[x];
    end
    o.head_id = list_head;
    o.tail_id = list_tail;
    return o;
  endfunction

  // drive one command and wait for its transfer
  task automatic send_cmd(ilra_pkg::cmd_t c, logic [ID_W-1:0] e);
    ilra_pkg::req_t r;
    ilra_pkg::rsp_t o;
    r.cmd   = c;
    r.entry = e;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    o = list_apply(r);
    result_q.push_back(o);
    cmd_seen[c]++;
    status_seen[o.status]++;
    do @(posedge clk); while (!req_ready);
  endtask

  // stop sending and wait until every response has come back
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(logic [PADDR_W-1:0] a, logic [PDATA_W-1:0] d);
    wait_idle();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (a == ADDR_ENTRY_COUNT) count_reg = d[ID_W-1:0];
    reg_writes++;
  endtask

  task automatic reg_check();
    wait_idle();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_ENTRY_COUNT;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[ID_W-1:0] !== count_reg) begin
      $error("entry_count readback: expected %0d, actual %0d", count_reg, prdata[ID_W-1:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void check_field(string name, logic [ID_W-1:0] want,
                                      logic [ID_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  // response side: random stall and compare each transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (result_q.size() == 0) begin
        $error("response transfer with nothing expected: status %0d", rsp.status);
        errors++;
      end else begin
        want_rsp = result_q.pop_front();
        check_field("status", ID_W'(want_rsp.status), ID_W'(rsp.status));
        check_field("next_id", want_rsp.next_id, rsp.next_id);
        check_field("prev_id", want_rsp.prev_id, rsp.prev_id);
        check_field("head_id", want_rsp.head_id, rsp.head_id);
        check_field("tail_id", want_rsp.tail_id, rsp.tail_id);
      end
    end
    rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // random id mostly inside the current list, retried a few times to hit a member
  function automatic logic [ID_W-1:0] member_id();
    int              span;
    int              tries;
    logic [ID_W-1:0] id;
    span = (list_span > 0) ? list_span : 8;
    id   = ID_W'($urandom_range(1, span));
    for (tries = 0; tries < 4 && !listed(id); tries++) id = ID_W'($urandom_range(1, span));
    return id;
  endfunction

  function automatic logic [ID_W-1:0] any_id();
    return ($urandom_range(0, 1) == 0) ? ID_W'(0) : ID_W'($urandom_range(0, ID_TOP));
  endfunction

  // commands before any init: empty list, every id rejected
  task automatic test_before_init();
    reg_check();
    send_cmd(ilra_pkg::CMD_QUERY, ID_W'(0));
    send_cmd(ilra_pkg::CMD_REMOVE, ID_W'(1));
    send_cmd(ilra_pkg::CMD_ADVANCE, ID_W'(MAX_ENTRIES));
  endtask

  // five entries: head, tail and middle cases, removed and out-of-range ids
  task automatic test_small_list();
    reg_write(ADDR_ENTRY_COUNT, PDATA_W'(5));
    reg_check();
    send_cmd(ilra_pkg::CMD_INIT, ID_W'(3));
    send_cmd(ilra_pkg::CMD_QUERY, ID_W'(0));
    send_cmd(ilra_pkg::CMD_ADVANCE, ID_W'(1));
    send_cmd(ilra_pkg::CMD_ADVANCE, ID_W'(5));
    send_cmd(ilra_pkg::CMD_REMOVE, ID_W'(1));
    send_cmd(ilra_pkg::CMD_REMOVE, ID_W'(4));
    send_cmd(ilra_pkg::CMD_REMOVE, ID_W'(3));
    send_cmd(ilra_pkg::CMD_REMOVE, ID_W'(3));
    send_cmd(ilra_pkg::CMD_ADVANCE, ID_W'(5));
    send_cmd(ilra_pkg::CMD_ADVANCE, ID_W'(0));
    send_cmd(ilra_pkg::CMD_QUERY, ID_W'(MAX_ENTRIES + 1));
    send_cmd(ilra_pkg::CMD_REMOVE, ID_W'(ID_TOP));
    send_cmd(ilra_pkg::CMD_REMOVE, ID_W'(5));
    send_cmd(ilra_pkg::CMD_REMOVE, ID_W'(2));
    send_cmd(ilra_pkg::CMD_QUERY, ID_W'(0));
  endtask

  // count extremes: one entry, empty list, saturation, write to an unused address
  task automatic test_count_extremes();
    reg_write(ADDR_ENTRY_COUNT, PDATA_W'(1));
    send_cmd(ilra_pkg::CMD_INIT, ID_W'(0));
    send_cmd(ilra_pkg::CMD_ADVANCE, ID_W'(1));
    send_cmd(ilra_pkg::CMD_REMOVE, ID_W'(1));
    reg_write(ADDR_ENTRY_COUNT, PDATA_W'(0));
    send_cmd(ilra_pkg::CMD_INIT, ID_W'(1));
    reg_write(ADDR_ENTRY_COUNT, {{(PDATA_W - ID_W){1'b1}}, ID_W'(ID_TOP)});
    reg_check();
    send_cmd(ilra_pkg::CMD_INIT, ID_W'(MAX_ENTRIES));
    send_cmd(ilra_pkg::CMD_ADVANCE, ID_W'(MAX_ENTRIES));
    reg_write(ADDR_ENTRY_COUNT, PDATA_W'(2));
    reg_write(ADDR_UNUSED, PDATA_W'(9));
    reg_check();
    send_cmd(ilra_pkg::CMD_INIT, ID_W'(2));
  endtask

  // rounds of: new count, init, then mostly member commands with some noise
  task automatic test_random_traffic(int snd_pct, int rcv_pct, int items);
    int                 sent;
    int                 run_len;
    int                 k;
    int                 pick;
    int                 steps;
    logic [ID_W-1:0]    id;
    logic [ID_W-1:0]    cnt;
    logic [PDATA_W-1:0] wdata;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        cnt = ID_W'($urandom_range(1, 24));
      end else if (pick < 84) begin
        cnt = ID_W'($urandom_range(25, 200));
      end else if (pick < 92) begin
        cnt = ID_W'(MAX_ENTRIES);
      end else if (pick < 97) begin
        cnt = ID_W'($urandom_range(MAX_ENTRIES + 1, ID_TOP));
      end else begin
        cnt = '0;
      end
      wdata           = $urandom();
      wdata[ID_W-1:0] = cnt;
      reg_write(ADDR_ENTRY_COUNT, wdata);
      if ($urandom_range(0, 7) == 0) reg_check();
      send_cmd(ilra_pkg::CMD_INIT, any_id());
      sent++;
      run_len = $urandom_range(20, 80);
      for (k = 0; k < run_len && sent < items; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          send_cmd(ilra_pkg::CMD_ADVANCE, member_id());
          sent++;
        end else if (pick < 50) begin
          send_cmd(ilra_pkg::CMD_REMOVE, member_id());
          sent++;
        end else if (pick < 62) begin
          send_cmd(ilra_pkg::CMD_QUERY, member_id());
          sent++;
        end else if (pick < 68) begin
          send_cmd(ilra_pkg::CMD_ADVANCE,
                   ($urandom_range(0, 1) == 0) ? list_head : list_tail);
          sent++;
        end else if (pick < 76) begin
          // in-order readout starting from the head
          id    = '0;
          steps = 0;
          do begin
            send_cmd(ilra_pkg::CMD_QUERY, id);
            sent++;
            steps++;
            id = (id == 0) ? list_head : succ_link[id];
          end while (id != 0 && steps < 24);
        end else if (pick < 99) begin
          send_cmd(ilra_pkg::cmd_t'($urandom_range(ilra_pkg::CMD_REMOVE,
                                                   ilra_pkg::CMD_QUERY)),
                   ID_W'($urandom_range(0, ID_TOP)));
          sent++;
        end else begin
          send_cmd(ilra_pkg::CMD_INIT, any_id());
          sent++;
        end
        // occasionally hold the sender until the block has drained
        if ($urandom_range(0, 59) == 0) wait_idle();
      end
    end
  endtask

  initial begin
    for (int i = 0; i <= MAX_ENTRIES; i++) begin
      on_list[i]   = 1'b0;
      succ_link[i] = '0;
      pred_link[i] = '0;
    end
    send_idle_pct = 28;
    recv_idle_pct = 53;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_before_init();
    test_small_list();
    test_count_extremes();
    test_random_traffic(28, 53, 500);
    test_random_traffic(53, 28, 500);
    test_random_traffic(0, 0, 500);

    wait_idle();
    repeat (END_WAIT) @(posedge clk);
    $display("covered %0d commands: init %0d, remove %0d, advance %0d, query %0d",
             cmd_seen[ilra_pkg::CMD_INIT] + cmd_seen[ilra_pkg::CMD_REMOVE] +
             cmd_seen[ilra_pkg::CMD_ADVANCE] + cmd_seen[ilra_pkg::CMD_QUERY],
             cmd_seen[ilra_pkg::CMD_INIT], cmd_seen[ilra_pkg::CMD_REMOVE],
             cmd_seen[ilra_pkg::CMD_ADVANCE], cmd_seen[ilra_pkg::CMD_QUERY]);
    $display("status mix: done %0d, no change %0d, rejected %0d; %0d register writes",
             status_seen[ilra_pkg::ST_DONE], status_seen[ilra_pkg::ST_SAME],
             status_seen[ilra_pkg::ST_BAD], reg_writes);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
